>>> sv/gbns_pkg.sv
// ----------------------------------------------------------------------------
// gbns_pkg
// Types and constants shared by the go-back-N segment sender.
// ----------------------------------------------------------------------------
package gbns_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [3:0] WINDOW_RESET = 4'd4;
    localparam logic [7:0] ACK_MAX      = 8'hFF;

    localparam logic [1:0] STATUS_BYTE   = 2'd0;
    localparam logic [1:0] STATUS_REJECT = 2'd1;
    localparam logic [1:0] STATUS_DONE   = 2'd2;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_ACK  = 1'b1;

    typedef enum logic [0:0] {
        REG_SENDER_ID   = 1'b0,
        REG_WINDOW_SIZE = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_LOAD   = 3'd0,
        ST_ACK    = 3'd1,
        ST_FETCH  = 3'd2,
        ST_STREAM = 3'd3,
        ST_STATUS = 3'd4
    } t_state;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] ack_number;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  seq_number;
        logic [2:0]  seg_length;
        logic [1:0]  byte_index;
        logic [7:0]  out_byte;
        logic [15:0] checksum;
        logic        last_of_segment;
        logic        last_of_run;
    } t_res;

    typedef struct packed {
        logic [15:0] sender_id;
        logic [3:0]  window_size;
    } t_cfg;

endpackage

>>> sv/gbns_req_if.sv
// ----------------------------------------------------------------------------
// gbns_req_if
// Request channel: message bytes and acknowledgement numbers.
// ----------------------------------------------------------------------------
interface gbns_req_if
    import gbns_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/gbns_res_if.sv
// ----------------------------------------------------------------------------
// gbns_res_if
// Result channel: segment bytes and status words.
// ----------------------------------------------------------------------------
interface gbns_res_if
    import gbns_pkg::*;
();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/gbns_ram.sv
// ----------------------------------------------------------------------------
// gbns_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module gbns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/gbns_cfg.sv
// ----------------------------------------------------------------------------
// gbns_cfg
// APB register file holding the sender id and the window size.
// ----------------------------------------------------------------------------
module gbns_cfg
    import gbns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_SENDER_ID:   n_cfg.sender_id   = pwdata[15:0];
                REG_WINDOW_SIZE: n_cfg.window_size = pwdata[3:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SENDER_ID:   prdata = CFG_DW'(r_cfg.sender_id);
            REG_WINDOW_SIZE: prdata = CFG_DW'(r_cfg.window_size);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sender_id   <= '0;
            r_cfg.window_size <= WINDOW_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/gbns_ctrl.sv
// ----------------------------------------------------------------------------
// gbns_ctrl
// Sequencer of the segment sender: loads the byte store, tracks the window
// and acknowledgements, and streams segments from the store.
// ----------------------------------------------------------------------------
module gbns_ctrl
    import gbns_pkg::*;
#(
    parameter int SEG_BYTES     = 4,
    parameter int SEGMENT_SLOTS = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  t_cfg                                     i_cfg,
    gbns_req_if.sink                                 i_req,
    gbns_res_if.source                               o_res,
    output logic                                     o_ram_we,
    output logic [$clog2(SEG_BYTES*SEGMENT_SLOTS)-1:0] o_ram_waddr,
    output logic [7:0]                               o_ram_wdata,
    output logic                                     o_ram_re,
    output logic [$clog2(SEG_BYTES*SEGMENT_SLOTS)-1:0] o_ram_raddr,
    input  logic [7:0]                               i_ram_rdata
);

    localparam int DEPTH = SEG_BYTES * SEGMENT_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(SEGMENT_SLOTS + 1);
    localparam int JW    = (SEG_BYTES > 1) ? $clog2(SEG_BYTES) : 1;
    localparam int LNW   = $clog2(SEG_BYTES + 1);
    localparam logic [AW-1:0] LEN_MAX  = AW'(DEPTH - 1);
    localparam logic [JW-1:0] FILL_TOP = JW'(SEG_BYTES - 1);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_msg_len, n_msg_len;
    logic [SW-1:0]   r_count, n_count;
    logic [JW-1:0]   r_fill, n_fill;
    logic            r_overflow, n_overflow;
    logic [7:0]      r_base, n_base;
    logic [3:0]      r_acks, n_acks;
    logic [SW-1:0]   r_seg, n_seg;
    logic [SW-1:0]   r_seg_end, n_seg_end;
    logic [AW-1:0]   r_addr, n_addr;
    logic [JW-1:0]   r_j, n_j;
    logic [LNW-1:0]  r_left, n_left;
    logic [LNW-1:0]  r_len, n_len;
    logic [15:0]     r_sum, n_sum;
    logic [1:0]      r_pend, n_pend;
    logic            r_out_valid, n_out_valid;
    t_res            r_out, n_out;

    logic            acc;
    logic            byte_acc;
    logic            ack_acc;
    logic            store_ok;
    logic            ovf_now;
    logic [AW-1:0]   msg_len_new;
    logic [SW-1:0]   cnt_new;
    logic [3:0]      w_eff;
    logic [7:0]      new_base;
    logic [3:0]      acks_inc;
    logic            round_done;
    logic            all_acked;
    logic [7:0]      setup_base;
    logic [SW-1:0]   setup_cnt;
    logic [8:0]      setup_end9;
    logic [SW-1:0]   setup_end;
    logic [SW-1:0]   setup_seg;
    logic [AW-1:0]   setup_addr;
    logic [AW-1:0]   rem;
    logic [LNW-1:0]  fetch_len;
    logic            out_free;
    logic            last_b;
    logic            last_run;
    logic [15:0]     sum_new;

    assign i_req.ready = (r_state == ST_LOAD) || (r_state == ST_ACK);
    assign acc         = i_req.valid && i_req.ready;
    assign byte_acc    = acc && (r_state == ST_LOAD) && (i_req.data.req_type == REQ_BYTE);
    assign ack_acc     = acc && (r_state == ST_ACK) && (i_req.data.req_type == REQ_ACK);

    assign store_ok    = r_msg_len < LEN_MAX;
    assign ovf_now     = r_overflow || !store_ok;
    assign msg_len_new = store_ok ? r_msg_len + AW'(1) : r_msg_len;
    assign cnt_new     = (store_ok && (r_fill == '0)) ? r_count + SW'(1) : r_count;

    assign w_eff    = (i_cfg.window_size == 4'd0) ? 4'd1 : i_cfg.window_size;
    assign new_base = (i_req.data.ack_number >= r_base) ?
                      ((i_req.data.ack_number == ACK_MAX) ? ACK_MAX
                                                          : i_req.data.ack_number + 8'd1)
                      : r_base;
    assign acks_inc   = r_acks + 4'd1;
    assign round_done = acks_inc >= w_eff;
    assign all_acked  = 9'(new_base) >= 9'(r_count);

    assign setup_base = (r_state == ST_ACK) ? new_base : 8'd0;
    assign setup_cnt  = (r_state == ST_ACK) ? r_count : cnt_new;
    assign setup_end9 = 9'(setup_base) + 9'(w_eff);
    assign setup_end  = (setup_end9 > 9'(setup_cnt)) ? setup_cnt : SW'(setup_end9);
    assign setup_seg  = SW'(setup_base);
    assign setup_addr = AW'(32'(setup_seg) * SEG_BYTES);

    assign rem       = r_msg_len - r_addr;
    assign fetch_len = (32'(rem) > SEG_BYTES) ? LNW'(SEG_BYTES) : LNW'(rem);

    assign out_free = !r_out_valid || o_res.ready;
    assign last_b   = r_left == LNW'(1);
    assign last_run = ((SW + 1)'(r_seg) + (SW + 1)'(1)) == (SW + 1)'(r_seg_end);
    assign sum_new  = r_sum + 16'(i_ram_rdata);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (byte_acc && i_req.data.last_byte) begin
                    n_state = ovf_now ? ST_STATUS : ST_FETCH;
                end
            end
            ST_ACK: begin
                if (ack_acc && round_done) begin
                    n_state = all_acked ? ST_STATUS : ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_STREAM;
            end
            ST_STREAM: begin
                if (out_free && last_b) begin
                    n_state = last_run ? ST_ACK : ST_FETCH;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        n_msg_len   = r_msg_len;
        n_count     = r_count;
        n_fill      = r_fill;
        n_overflow  = r_overflow;
        n_base      = r_base;
        n_acks      = r_acks;
        n_seg       = r_seg;
        n_seg_end   = r_seg_end;
        n_addr      = r_addr;
        n_j         = r_j;
        n_left      = r_left;
        n_len       = r_len;
        n_sum       = r_sum;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_msg_len;
        o_ram_wdata = i_req.data.data_byte;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_addr;

        unique case (r_state)
            ST_LOAD: begin
                if (byte_acc) begin
                    if (store_ok) begin
                        o_ram_we  = 1'b1;
                        n_msg_len = msg_len_new;
                        n_count   = cnt_new;
                        n_fill    = (r_fill == FILL_TOP) ? '0 : r_fill + JW'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_req.data.last_byte) begin
                        n_base = 8'd0;
                        n_acks = 4'd0;
                        if (ovf_now) begin
                            n_msg_len  = '0;
                            n_count    = '0;
                            n_fill     = '0;
                            n_overflow = 1'b0;
                            n_pend     = STATUS_REJECT;
                        end else begin
                            n_seg     = setup_seg;
                            n_seg_end = setup_end;
                            n_addr    = setup_addr;
                        end
                    end
                end
            end
            ST_ACK: begin
                if (ack_acc) begin
                    n_base = new_base;
                    n_acks = acks_inc;
                    if (round_done) begin
                        n_acks = 4'd0;
                        if (all_acked) begin
                            n_msg_len  = '0;
                            n_count    = '0;
                            n_fill     = '0;
                            n_overflow = 1'b0;
                            n_base     = 8'd0;
                            n_pend     = STATUS_DONE;
                        end else begin
                            n_seg     = setup_seg;
                            n_seg_end = setup_end;
                            n_addr    = setup_addr;
                        end
                    end
                end
            end
            ST_FETCH: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = r_addr;
                n_len       = fetch_len;
                n_left      = fetch_len;
                n_j         = '0;
                n_sum       = 16'(i_cfg.sender_id[7:0]) + 16'(i_cfg.sender_id[15:8])
                              + 16'(r_seg);
            end
            ST_STREAM: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = STATUS_BYTE;
                    n_out.seq_number      = 3'(r_seg);
                    n_out.seg_length      = 3'(r_len);
                    n_out.byte_index      = 2'(r_j);
                    n_out.out_byte        = i_ram_rdata;
                    n_out.checksum        = last_b ? sum_new : 16'd0;
                    n_out.last_of_segment = last_b;
                    n_out.last_of_run     = last_b && last_run;
                    n_addr                = r_addr + AW'(1);
                    if (last_b) begin
                        if (!last_run) begin
                            n_seg = r_seg + SW'(1);
                        end
                    end else begin
                        n_j         = r_j + JW'(1);
                        n_left      = r_left - LNW'(1);
                        n_sum       = sum_new;
                        o_ram_re    = 1'b1;
                        o_ram_raddr = r_addr + AW'(1);
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.status      = r_pend;
                    n_out.last_of_run = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !o_res.ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_msg_len   <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_overflow  <= 1'b0;
            r_base      <= 8'd0;
            r_acks      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_msg_len   <= n_msg_len;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_overflow  <= n_overflow;
            r_base      <= n_base;
            r_acks      <= n_acks;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg     <= n_seg;
        r_seg_end <= n_seg_end;
        r_addr    <= n_addr;
        r_j       <= n_j;
        r_left    <= n_left;
        r_len     <= n_len;
        r_sum     <= n_sum;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

>>> sv/go_back_n_segment_sender_core.sv
// ----------------------------------------------------------------------------
// go_back_n_segment_sender_core
// Go-back-N sender that stores a message, cuts it into segments and streams
// each window of segments with a running checksum on every segment.
//
// Words enter on i_req (valid/ready) and leave on o_res (valid/ready). In the
// idle phase each message byte word is taken and written to an on-chip byte
// RAM; the word marked last starts the first window. While waiting for
// acknowledgements each ack word is taken; after window_size of them (zero
// counts as one) the window is resent from the new base, or a status word
// reports that every segment is acknowledged. An overlong message ends in a
// single reject status word.
// A window burst reads the first byte of each segment in a fetch state and
// the rest while the segment streams through the output register.
// No request is taken while a burst streams. When the receiver stalls, the
// output register holds its word and the stream waits on it. The byte RAM
// needs no clearing: after reset only written entries are ever read, and the
// control state is cleared by reset. Registers are written over APB.
// ----------------------------------------------------------------------------
module go_back_n_segment_sender_core
    import gbns_pkg::*;
#(
    parameter int SEG_BYTES     = 4,
    parameter int SEGMENT_SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gbns_req_if.sink          i_req,
    gbns_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int DEPTH = SEG_BYTES * SEGMENT_SLOTS;
    localparam int AW    = $clog2(DEPTH);

    t_cfg          cfg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    gbns_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gbns_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gbns_ctrl #(
        .SEG_BYTES     (SEG_BYTES),
        .SEGMENT_SLOTS (SEGMENT_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .o_res       (o_res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // The store is loaded and streamed in separate phases.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("byte store read and written in the same cycle");

    a_no_accept_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> !ram_re)
        else $error("request word taken while the store is being read");

    // A read is always followed by a streaming cycle that holds off requests.
    a_read_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> !i_req.ready)
        else $error("request channel opened before read data was consumed");

    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.data.status != STATUS_BYTE)) |->
        (o_res.data.last_of_run && !o_res.data.last_of_segment))
        else $error("status word does not end its run");

endmodule

>>> tb/go_back_n_segment_sender_core_tb.sv
// ----------------------------------------------------------------------------
// go_back_n_segment_sender_core_tb
// Self-checking testbench for the go-back-N segment sender. Message bytes and
// acknowledgements are driven over the request channel while a bit-accurate
// predictor of the sender builds the expected segment and status words.
// Every word leaving the block is compared field by field against the oldest
// expected word. Directed cases, overlong messages, randomized traffic under
// several idling mixes and a long receiver hold-off are run in turn.
// ----------------------------------------------------------------------------
module go_back_n_segment_sender_core_tb;
    import gbns_pkg::*;

    localparam int          SEG_BYTES      = 4;
    localparam int          SEGMENT_SLOTS  = 8;
    localparam int          STORE_DEPTH    = SEG_BYTES * SEGMENT_SLOTS;
    localparam int          MAX_LEN        = STORE_DEPTH - 1;
    localparam logic [7:0]  ACK_TOP        = 8'd254;
    localparam int          TX_GAP_MAX     = 20;
    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          WATCHDOG_LIMIT = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    gbns_req_if req_bus ();
    gbns_res_if res_bus ();

    go_back_n_segment_sender_core #(
        .SEG_BYTES     (SEG_BYTES),
        .SEGMENT_SLOTS (SEGMENT_SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [7:0]  msg_store [STORE_DEPTH];
    int unsigned msg_len;
    logic [7:0]  win_base;
    int unsigned acks_count;
    bit          in_wait;
    bit          msg_overflow;
    logic [15:0] cfg_device;
    logic [3:0]  cfg_window;

    t_res        words_due [$];
    int unsigned words_taken = 0;
    int unsigned err_count   = 0;
    int unsigned stall_count = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    logic        rx_hold;
    event        rx_hold_go;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned seg_total();
        return (msg_len + SEG_BYTES - 1) / SEG_BYTES;
    endfunction

    function automatic int unsigned window_eff();
        return (cfg_window == 4'd0) ? 1 : int'(cfg_window);
    endfunction

    function automatic void clear_message();
        in_wait      = 1'b0;
        msg_len      = 0;
        msg_overflow = 1'b0;
        acks_count   = 0;
        win_base     = 8'd0;
    endfunction

    function automatic void push_status(input logic [1:0] st);
        t_res r;
        r             = '0;
        r.status      = st;
        r.last_of_run = 1'b1;
        words_due.push_back(r);
    endfunction

    function automatic void push_window();
        int unsigned first;
        int unsigned base_pos;
        int unsigned len;
        logic [15:0] sum;
        t_res        r;
        first = words_due.size();
        for (int unsigned s = win_base; s < seg_total() && s < win_base + window_eff(); s++) begin
            base_pos = s * SEG_BYTES;
            len      = msg_len - base_pos;
            if (len > SEG_BYTES) begin
                len = SEG_BYTES;
            end
            sum = 16'(cfg_device[7:0]) + 16'(cfg_device[15:8]) + 16'(8'(s));
            for (int unsigned j = 0; j < len; j++) begin
                sum          = sum + 16'(msg_store[base_pos + j]);
                r            = '0;
                r.status     = STATUS_BYTE;
                r.seq_number = 3'(s);
                r.seg_length = 3'(len);
                r.byte_index = 2'(j);
                r.out_byte   = msg_store[base_pos + j];
                if (j + 1 == len) begin
                    r.checksum        = sum;
                    r.last_of_segment = 1'b1;
                end
                words_due.push_back(r);
            end
        end
        if (words_due.size() > first) begin
            words_due[$].last_of_run = 1'b1;
        end
    endfunction

    // Advances the sender state by one accepted word; returns 0 for ignored words.
    function automatic bit fold_word(input t_req w);
        if (!in_wait) begin
            if (w.req_type != REQ_BYTE) begin
                return 1'b0;
            end
            if (msg_len < MAX_LEN) begin
                msg_store[msg_len] = w.data_byte;
                msg_len++;
            end else begin
                msg_overflow = 1'b1;
            end
            if (!w.last_byte) begin
                return 1'b1;
            end
            if (msg_overflow) begin
                clear_message();
                push_status(STATUS_REJECT);
                return 1'b1;
            end
            in_wait    = 1'b1;
            win_base   = 8'd0;
            acks_count = 0;
            push_window();
            return 1'b1;
        end
        if (w.req_type != REQ_ACK) begin
            return 1'b0;
        end
        if (w.ack_number >= win_base) begin
            win_base = (w.ack_number == ACK_MAX) ? ACK_MAX : w.ack_number + 8'd1;
        end
        acks_count++;
        if (acks_count < window_eff()) begin
            return 1'b1;
        end
        acks_count = 0;
        if (win_base >= seg_total()) begin
            clear_message();
            push_status(STATUS_DONE);
        end else begin
            push_window();
        end
        return 1'b1;
    endfunction

    function automatic t_req byte_word(input logic [7:0] data, input logic last);
        t_req w;
        w.req_type   = REQ_BYTE;
        w.data_byte  = data;
        w.last_byte  = last;
        w.ack_number = 8'($urandom_range(255));
        return w;
    endfunction

    function automatic t_req ack_word(input logic [7:0] ack);
        t_req w;
        w.req_type   = REQ_ACK;
        w.data_byte  = 8'($urandom_range(255));
        w.last_byte  = 1'($urandom_range(1));
        w.ack_number = ack;
        return w;
    endfunction

    function automatic logic [7:0] pick_ack(input int unsigned rounds);
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(99);
        if (rounds > 40) begin
            pick = 32'(ACK_TOP);
        end else if (roll < 65) begin
            pick = win_base + $urandom_range(window_eff() - 1);
        end else if (roll < 85 && win_base > 0) begin
            pick = $urandom_range(win_base - 1);
        end else begin
            pick = $urandom_range(ACK_TOP);
        end
        if (pick > ACK_TOP) begin
            pick = 32'(ACK_TOP);
        end
        return 8'(pick);
    endfunction

    task automatic report(input string what);
        err_count++;
        $display("mismatch: %s", what);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic offer_word(input t_req w);
        int unsigned gap;
        gap = 0;
        while (gap < TX_GAP_MAX && $urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= w;
        do @(posedge i_clk); while (!req_bus.ready);
        if (fold_word(w)) begin
            words_taken++;
        end
    endtask

    task automatic settle();
        req_bus.valid <= 1'b0;
        while (words_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SENDER_ID:   cfg_device = value[15:0];
            REG_WINDOW_SIZE: cfg_window = value[3:0];
            default: ;
        endcase
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned k = 0; k < len; k++) begin
            offer_word(byte_word(8'($urandom_range(255)), k + 1 == len));
        end
    endtask

    task automatic run_acks();
        int unsigned rounds;
        rounds = 0;
        while (in_wait) begin
            if ($urandom_range(99) < 8) begin
                offer_word(byte_word(8'($urandom_range(255)), 1'($urandom_range(1))));
            end
            offer_word(ack_word(pick_ack(rounds)));
            rounds++;
        end
    endtask

    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        offer_word(ack_word(8'h55));
        offer_word(byte_word(8'h00, 1'b1));
        offer_word(byte_word(8'hAA, 1'b1));
        repeat (4) offer_word(ack_word(8'd0));
        offer_word(byte_word(8'hFF, 1'b0));
        offer_word(byte_word(8'h00, 1'b0));
        offer_word(byte_word(8'hFF, 1'b0));
        offer_word(byte_word(8'h80, 1'b0));
        offer_word(byte_word(8'h01, 1'b1));
        repeat (4) offer_word(ack_word(ACK_TOP));
        settle();
        write_reg(REG_SENDER_ID, 32'h0000_FFFF);
        write_reg(REG_WINDOW_SIZE, 32'd0);
        offer_word(byte_word(8'hFF, 1'b0));
        offer_word(byte_word(8'hFF, 1'b1));
        offer_word(ack_word(8'd0));
    endtask

    task automatic test_overflow();
        settle();
        write_reg(REG_SENDER_ID, 32'd0);
        write_reg(REG_WINDOW_SIZE, 32'd8);
        send_message(MAX_LEN);
        run_acks();
        send_message(MAX_LEN + 1);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic [3:0] win, input int unsigned quota);
        int unsigned first;
        int unsigned roll;
        int unsigned len;
        settle();
        write_reg(REG_SENDER_ID, $urandom_range(16'hFFFF));
        write_reg(REG_WINDOW_SIZE, 32'(win));
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        first        = words_taken;
        while (words_taken - first < quota) begin
            if ($urandom_range(99) < 10) begin
                offer_word(ack_word(8'($urandom_range(ACK_TOP))));
            end
            roll = $urandom_range(99);
            if (roll < 70) begin
                len = $urandom_range(8, 1);
            end else if (roll < 96) begin
                len = $urandom_range(20, 9);
            end else if (roll < 98) begin
                len = $urandom_range(MAX_LEN, 21);
            end else begin
                len = $urandom_range(MAX_LEN + 2, MAX_LEN + 1);
            end
            send_message(len);
            run_acks();
        end
    endtask

    task automatic test_backpressure();
        settle();
        write_reg(REG_WINDOW_SIZE, 32'd8);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        -> rx_hold_go;
        send_message(MAX_LEN);
        run_acks();
    endtask

    initial begin
        rx_hold = 1'b0;
        forever begin
            @(rx_hold_go);
            rx_hold <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        res_bus.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin : check_words
        t_res got;
        t_res want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got = res_bus.data;
            if (words_due.size() == 0) begin
                report($sformatf("unexpected word %h", got));
            end else begin
                want = words_due.pop_front();
                compare_field("status", int'(got.status), int'(want.status));
                compare_field("seq_number", int'(got.seq_number), int'(want.seq_number));
                compare_field("seg_length", int'(got.seg_length), int'(want.seg_length));
                compare_field("byte_index", int'(got.byte_index), int'(want.byte_index));
                compare_field("out_byte", int'(got.out_byte), int'(want.out_byte));
                compare_field("checksum", int'(got.checksum), int'(want.checksum));
                compare_field("last_of_segment", int'(got.last_of_segment),
                              int'(want.last_of_segment));
                compare_field("last_of_run", int'(got.last_of_run), int'(want.last_of_run));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (req_bus.valid && req_bus.ready)
                || (res_bus.valid && res_bus.ready)) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("go_back_n_segment_sender_core_tb: done, errors");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.data  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            msg_store[i] = 8'd0;
        end
        clear_message();
        cfg_device = 16'd0;
        cfg_window = WINDOW_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_random_traffic(0, 0, 4'd1, 40);
        test_random_traffic(68, 0, 4'd8, 40);
        test_random_traffic(0, 68, 4'($urandom_range(7, 2)), 40);
        test_random_traffic(32, 32, 4'($urandom_range(8, 1)), 40);
        test_backpressure();
        settle();
        if (err_count == 0) begin
            $display("go_back_n_segment_sender_core_tb: done, clean");
        end else begin
            $display("go_back_n_segment_sender_core_tb: done, errors");
        end
        $finish;
    end
endmodule

>>> go_back_n_segment_sender_core.f
sv/gbns_pkg.sv
sv/gbns_req_if.sv
sv/gbns_res_if.sv
sv/gbns_ram.sv
sv/gbns_cfg.sv
sv/gbns_ctrl.sv
sv/go_back_n_segment_sender_core.sv
tb/go_back_n_segment_sender_core_tb.sv
